>>> rtl/core/gmp_pkg.sv
// ----------------------------------------------------------------------------
// gmp_pkg: shared types and constants
// Window geometry, arithmetic widths and the controller-to-datapath
// command and status groups of the pen-position median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gmp_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

    localparam int COORD_W    = 32;
    localparam int ACC_W      = 64;
    localparam int SQ_W       = 65;
    localparam int DIST_W     = 33;
    localparam int WT_W       = 32;
    localparam int DEN_W      = 32;

    localparam int DIV_NW     = 64;
    localparam int DIV_DW     = 34;
    localparam int SQRT_W     = 64;
    localparam int ROOT_W     = 32;

    localparam int ITER_W     = 5;
    localparam int THR_W      = 31;
    localparam int WLEN_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_ITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WLEN = 2'd2;

    localparam logic [ITER_W-1:0] ITER_RESET = 5'd10;
    localparam logic [THR_W-1:0]  THR_RESET  = '0;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd10;

    // 0.001 in Q17.16, rounded to nearest
    localparam logic [DIST_W-1:0] DMIN = 33'd66;
    // numerator of every weight: 1.0 scaled by 2^16 twice
    localparam logic [DIV_NW-1:0] WEIGHT_ONE = 64'h0000_0001_0000_0000;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic clear_win;
        logic push;
        logic acc_clr;
        logic mean_acc;
        logic set_den_n;
        logic dx_pt;
        logic dx_smp;
        logic sq_x;
        logic sq_y;
        logic sq_add;
        logic sqrt_start;
        logic ld_d;
        logic wdiv_start;
        logic wt_ld;
        logic k_inc;
        logic k_clr;
        logic wm_x;
        logic wm_y;
        logic wm_acc_y;
        logic cdiv_x_start;
        logic cx_ld;
        logic cdiv_y_start;
        logic cy_ld;
        logic it_inc;
        logic out_ld;
        logic out_sel_smp;
        logic out_cleared;
    } t_cmd;

    typedef struct packed {
        logic n_le1;
        logic k_last;
        logic den_zero;
        logic it_done;
        logic sqrt_done;
        logic div_done;
        logic jump;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/core/gmp_div.sv
// ----------------------------------------------------------------------------
// gmp_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_div
    import gmp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    output logic      [DIV_NW-1:0] o_quot,
    output logic                   o_done
);

    localparam int CW = $clog2(DIV_NW);

    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_dvs;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   w_sh;
    logic              w_ge;

    always_comb begin
        w_sh  = {r_rem, r_quo[DIV_NW-1]};
        w_ge  = (w_sh >= {1'b0, r_dvs});
        n_rem = w_ge ? DIV_DW'(w_sh - {1'b0, r_dvs}) : w_sh[DIV_DW-1:0];
        n_quo = {r_quo[DIV_NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_dvs <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/core/gmp_sqrt.sv
// ----------------------------------------------------------------------------
// gmp_sqrt: iterative integer square root
// Digit-by-digit floor root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_sqrt
    import gmp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SQRT_W-1:0] i_val,
    output logic      [ROOT_W-1:0] o_root,
    output logic                   o_done
);

    localparam int CW = $clog2(ROOT_W);

    logic [SQRT_W-1:0] r_v, r_r, r_b;
    logic [SQRT_W-1:0] w_t;
    logic [CW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;

    assign w_t = r_r + r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_r <= '0;
            r_b <= SQRT_W'(1) << (SQRT_W - 2);
        end else if (r_busy) begin
            if (r_v >= w_t) begin
                r_v <= r_v - w_t;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_root = r_r[ROOT_W-1:0];
    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/core/gmp_datapath.sv
// ----------------------------------------------------------------------------
// gmp_datapath: window store and arithmetic
// History ring, accumulators, shared multiplier, root and divide units and
// the output register, all driven by controller commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_datapath
    import gmp_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_cmd                      i_cmd,
    output t_sts                           o_sts,
    input  wire logic signed [COORD_W-1:0] i_sample_x,
    input  wire logic signed [COORD_W-1:0] i_sample_y,
    input  wire logic        [ITER_W-1:0]  i_iteration_count,
    input  wire logic        [THR_W-1:0]   i_jump_threshold,
    input  wire logic        [WLEN_W-1:0]  i_window_length,
    output logic signed      [COORD_W-1:0] o_out_x,
    output logic signed      [COORD_W-1:0] o_out_y,
    output logic                           o_window_cleared
);

    logic signed [COORD_W-1:0] r_hist_x [MAX_WINDOW];
    logic signed [COORD_W-1:0] r_hist_y [MAX_WINDOW];
    logic        [WT_W-1:0]    r_wt     [MAX_WINDOW];
    logic [PTR_W-1:0]          r_wp;
    logic [CNT_W-1:0]          r_fill;
    logic [CNT_W-1:0]          r_n;
    logic [PTR_W-1:0]          r_k;
    logic [ITER_W-1:0]         r_it;

    logic signed [COORD_W-1:0] r_sx, r_sy, r_cx, r_cy;
    logic signed [ACC_W-1:0]   r_accx, r_accy;
    logic [DEN_W-1:0]          r_den;
    logic [COORD_W-1:0]        r_ax, r_ay;
    logic [ACC_W-1:0]          r_prod;
    logic [SQ_W-1:0]           r_sumsq;
    logic [DIST_W-1:0]         r_d;

    logic signed [COORD_W-1:0] r_out_x, r_out_y;
    logic                      r_out_clr;

    logic [PTR_W-1:0]          w_idx;
    logic [PTR_W:0]            w_idx_sum;
    logic signed [COORD_W-1:0] w_px, w_py, w_ox, w_oy;
    logic [CNT_W-1:0]          w_len, w_fill_nx, w_n_nx;
    logic signed [COORD_W:0]   w_dx, w_dy;
    logic [COORD_W:0]          w_adx, w_ady;
    logic signed [COORD_W:0]   w_ma, w_mb;
    logic signed [2*COORD_W+1:0] w_mp;
    logic [SQRT_W-1:0]         w_sq_in;
    logic [ROOT_W-1:0]         w_root;
    logic                      w_sqrt_done;
    logic [DIST_W-1:0]         w_dw;
    logic [DIV_NW-1:0]         w_div_num, w_quot;
    logic [DIV_DW-1:0]         w_div_den;
    logic                      w_div_start, w_div_done;
    logic signed [ACC_W-1:0]   w_cnum;
    logic signed [ACC_W-1:0]   w_qadj;

    // newest entry sits one behind the write pointer
    always_comb begin
        w_idx_sum = {1'b0, r_wp} + (PTR_W+1)'(MAX_WINDOW - 1) - {1'b0, r_k};
        if (w_idx_sum >= (PTR_W+1)'(MAX_WINDOW))
            w_idx = PTR_W'(w_idx_sum - (PTR_W+1)'(MAX_WINDOW));
        else
            w_idx = w_idx_sum[PTR_W-1:0];
        w_px = r_hist_x[w_idx];
        w_py = r_hist_y[w_idx];
    end

    always_comb begin
        if (i_window_length == '0)
            w_len = CNT_W'(1);
        else if (32'(i_window_length) > MAX_WINDOW)
            w_len = CNT_W'(MAX_WINDOW);
        else
            w_len = CNT_W'(i_window_length);
        w_fill_nx = (32'(r_fill) < MAX_WINDOW) ? r_fill + 1'b1 : r_fill;
        w_n_nx    = (w_fill_nx < w_len) ? w_fill_nx : w_len;
    end

    // distance operands: candidate to window point, or sample to candidate
    always_comb begin
        if (i_cmd.dx_smp) begin
            w_dx = {r_sx[COORD_W-1], r_sx} - {r_cx[COORD_W-1], r_cx};
            w_dy = {r_sy[COORD_W-1], r_sy} - {r_cy[COORD_W-1], r_cy};
        end else begin
            w_dx = {r_cx[COORD_W-1], r_cx} - {w_px[COORD_W-1], w_px};
            w_dy = {r_cy[COORD_W-1], r_cy} - {w_py[COORD_W-1], w_py};
        end
        w_adx = w_dx[COORD_W] ? (COORD_W+1)'(-w_dx) : w_dx;
        w_ady = w_dy[COORD_W] ? (COORD_W+1)'(-w_dy) : w_dy;
    end

    // single shared multiplier
    always_comb begin
        w_ma = {1'b0, r_ax};
        w_mb = {1'b0, r_ax};
        if (i_cmd.sq_y) begin
            w_ma = {1'b0, r_ay};
            w_mb = {1'b0, r_ay};
        end else if (i_cmd.wm_x) begin
            w_ma = {w_px[COORD_W-1], w_px};
            w_mb = {1'b0, r_wt[r_k]};
        end else if (i_cmd.wm_y) begin
            w_ma = {w_py[COORD_W-1], w_py};
            w_mb = {1'b0, r_wt[r_k]};
        end
        w_mp = w_ma * w_mb;
    end

    // sums of 2^64 and above take the root of a quarter and double it
    assign w_sq_in = r_sumsq[SQ_W-1] ? {1'b0, r_sumsq[SQ_W-1:2]} : r_sumsq[SQRT_W-1:0];
    assign w_dw    = (r_d < DMIN) ? DMIN : r_d;

    // floor division: a negative numerator divides its complement
    always_comb begin
        w_cnum = (i_cmd.cdiv_y_start || i_cmd.cy_ld) ? r_accy : r_accx;
        if (i_cmd.wdiv_start) begin
            w_div_num = WEIGHT_ONE;
            w_div_den = DIV_DW'(w_dw);
        end else begin
            w_div_num = w_cnum[ACC_W-1] ? ~w_cnum : w_cnum;
            w_div_den = DIV_DW'(r_den);
        end
        w_div_start = i_cmd.wdiv_start | i_cmd.cdiv_x_start | i_cmd.cdiv_y_start;
        w_qadj      = w_cnum[ACC_W-1] ? ~w_quot : w_quot;
        w_ox        = i_cmd.out_sel_smp ? r_sx : r_cx;
        w_oy        = i_cmd.out_sel_smp ? r_sy : r_cy;
    end

    gmp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_val   (w_sq_in),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    gmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear_win) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_cmd.push) begin
            r_wp   <= (32'(r_wp) == MAX_WINDOW - 1) ? '0 : r_wp + 1'b1;
            r_fill <= w_fill_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_hist_x[r_wp] <= i_sample_x;
            r_hist_y[r_wp] <= i_sample_y;
            r_sx           <= i_sample_x;
            r_sy           <= i_sample_y;
            r_n            <= w_n_nx;
        end

        if (i_cmd.push || i_cmd.acc_clr) begin
            r_accx <= '0;
            r_accy <= '0;
            r_den  <= '0;
        end else if (i_cmd.mean_acc) begin
            r_accx <= r_accx + ACC_W'(w_px);
            r_accy <= r_accy + ACC_W'(w_py);
            // point count loaded with the last mean term
            if (i_cmd.set_den_n)
                r_den <= DEN_W'(r_n);
        end else if (i_cmd.set_den_n) begin
            r_den <= DEN_W'(r_n);
        end else if (i_cmd.wt_ld) begin
            r_wt[r_k] <= w_quot[WT_W-1:0];
            r_den     <= r_den + w_quot[DEN_W-1:0];
        end else if (i_cmd.wm_y) begin
            r_accx <= r_accx + $signed(r_prod);
        end else if (i_cmd.wm_acc_y) begin
            r_accy <= r_accy + $signed(r_prod);
        end

        if (i_cmd.push || i_cmd.acc_clr || i_cmd.k_clr)
            r_k <= '0;
        else if (i_cmd.mean_acc || i_cmd.k_inc)
            r_k <= r_k + 1'b1;

        if (i_cmd.push)
            r_it <= '0;
        else if (i_cmd.it_inc)
            r_it <= r_it + 1'b1;

        if (i_cmd.dx_pt || i_cmd.dx_smp) begin
            r_ax <= w_adx[COORD_W-1:0];
            r_ay <= w_ady[COORD_W-1:0];
        end

        if (i_cmd.sq_x || i_cmd.sq_y || i_cmd.wm_x || i_cmd.wm_y)
            r_prod <= w_mp[ACC_W-1:0];

        if (i_cmd.sq_y)
            r_sumsq <= {1'b0, r_prod};
        else if (i_cmd.sq_add)
            r_sumsq <= r_sumsq + {1'b0, r_prod};

        if (i_cmd.ld_d)
            r_d <= r_sumsq[SQ_W-1] ? {w_root, 1'b0} : {1'b0, w_root};

        if (i_cmd.cx_ld)
            r_cx <= w_qadj[COORD_W-1:0];
        if (i_cmd.cy_ld)
            r_cy <= w_qadj[COORD_W-1:0];

        if (i_cmd.out_ld) begin
            r_out_x   <= w_ox;
            r_out_y   <= w_oy;
            r_out_clr <= i_cmd.out_cleared;
        end
    end

    always_comb begin
        o_sts.n_le1     = (r_n <= CNT_W'(1));
        o_sts.k_last    = ({1'b0, r_k} == CNT_W'(r_n - 1'b1));
        o_sts.den_zero  = (r_den == '0);
        o_sts.it_done   = (r_it == i_iteration_count);
        o_sts.sqrt_done = w_sqrt_done;
        o_sts.div_done  = w_div_done;
        o_sts.jump      = (r_d > DIST_W'(i_jump_threshold));
    end

    assign o_out_x          = r_out_x;
    assign o_out_y          = r_out_y;
    assign o_window_cleared = r_out_clr;

endmodule

`default_nettype wire

>>> rtl/core/gmp_ctrl.sv
// ----------------------------------------------------------------------------
// gmp_ctrl: sequencing state machine
// Steps the mean, the refinement passes and the jump test through the
// datapath, and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gmp_ctrl
    import gmp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_in_op,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [21:0] {
        S_IDLE  = 22'b0000000000000000000001,
        S_START = 22'b0000000000000000000010,
        S_MEAN  = 22'b0000000000000000000100,
        S_DIVX  = 22'b0000000000000000001000,
        S_DIVXW = 22'b0000000000000000010000,
        S_DIVY  = 22'b0000000000000000100000,
        S_DIVYW = 22'b0000000000000001000000,
        S_ITCHK = 22'b0000000000000010000000,
        S_DPT   = 22'b0000000000000100000000,
        S_SQX   = 22'b0000000000001000000000,
        S_SQY   = 22'b0000000000010000000000,
        S_SADD  = 22'b0000000000100000000000,
        S_SQRT  = 22'b0000000001000000000000,
        S_SQRTW = 22'b0000000010000000000000,
        S_WDIV  = 22'b0000000100000000000000,
        S_WDIVW = 22'b0000001000000000000000,
        S_WCHK  = 22'b0000010000000000000000,
        S_WMX   = 22'b0000100000000000000000,
        S_WMY   = 22'b0001000000000000000000,
        S_WAY   = 22'b0010000000000000000000,
        S_JCMP  = 22'b0100000000000000000000,
        S_OUT   = 22'b1000000000000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_mean, n_mean;
    logic   r_jmp, n_jmp;
    logic   r_sel, n_sel;
    logic   r_clr, n_clr;
    logic   r_ovld, n_ovld;

    always_comb begin
        n_state = r_state;
        n_mean  = r_mean;
        n_jmp   = r_jmp;
        n_sel   = r_sel;
        n_clr   = r_clr;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_op == OP_CLEAR) begin
                        o_cmd.clear_win = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                        n_state    = S_START;
                    end
                end
            end
            S_START: begin
                if (i_sts.n_le1) begin
                    n_sel   = 1'b1;
                    n_clr   = 1'b0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_state       = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.mean_acc = 1'b1;
                if (i_sts.k_last) begin
                    n_mean  = 1'b1;
                    n_state = S_DIVX;
                end
            end
            S_DIVX: begin
                o_cmd.cdiv_x_start = 1'b1;
                n_state            = S_DIVXW;
            end
            S_DIVXW: begin
                if (i_sts.div_done) begin
                    o_cmd.cx_ld = 1'b1;
                    n_state     = S_DIVY;
                end
            end
            S_DIVY: begin
                o_cmd.cdiv_y_start = 1'b1;
                n_state            = S_DIVYW;
            end
            S_DIVYW: begin
                if (i_sts.div_done) begin
                    o_cmd.cy_ld  = 1'b1;
                    o_cmd.it_inc = !r_mean;
                    n_mean       = 1'b0;
                    n_state      = S_ITCHK;
                end
            end
            S_ITCHK: begin
                if (i_sts.it_done) begin
                    n_jmp = 1'b1;
                end else begin
                    n_jmp         = 1'b0;
                    o_cmd.acc_clr = 1'b1;
                end
                n_state = S_DPT;
            end
            S_DPT: begin
                o_cmd.dx_smp = r_jmp;
                o_cmd.dx_pt  = !r_jmp;
                n_state      = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_SADD;
            end
            S_SADD: begin
                o_cmd.sq_add = 1'b1;
                n_state      = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = S_SQRTW;
            end
            S_SQRTW: begin
                if (i_sts.sqrt_done) begin
                    o_cmd.ld_d = 1'b1;
                    n_state    = r_jmp ? S_JCMP : S_WDIV;
                end
            end
            S_WDIV: begin
                o_cmd.wdiv_start = 1'b1;
                n_state          = S_WDIVW;
            end
            S_WDIVW: begin
                if (i_sts.div_done) begin
                    o_cmd.wt_ld = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.k_clr = 1'b1;
                        n_state     = S_WCHK;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_DPT;
                    end
                end
            end
            S_WCHK: begin
                // all weights zero: candidate stays for this step
                if (i_sts.den_zero) begin
                    o_cmd.it_inc = 1'b1;
                    n_state      = S_ITCHK;
                end else begin
                    n_state = S_WMX;
                end
            end
            S_WMX: begin
                o_cmd.wm_x = 1'b1;
                n_state    = S_WMY;
            end
            S_WMY: begin
                o_cmd.wm_y = 1'b1;
                n_state    = S_WAY;
            end
            S_WAY: begin
                o_cmd.wm_acc_y = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_DIVX;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_WMX;
                end
            end
            S_JCMP: begin
                if (i_sts.jump) begin
                    o_cmd.clear_win = 1'b1;
                    n_sel           = 1'b1;
                    n_clr           = 1'b1;
                end else begin
                    n_sel = 1'b0;
                    n_clr = 1'b0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovld || i_out_ready) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // mean denominator is loaded as the accumulation finishes
        if (r_state == S_MEAN && i_sts.k_last) o_cmd.set_den_n = 1'b1;
        o_cmd.out_sel_smp = r_sel;
        o_cmd.out_cleared = r_clr;
        if (o_cmd.out_ld)
            n_ovld = 1'b1;
        else if (i_out_ready)
            n_ovld = 1'b0;
        else
            n_ovld = r_ovld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mean  <= 1'b0;
            r_jmp   <= 1'b0;
            r_sel   <= 1'b0;
            r_clr   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mean  <= n_mean;
            r_jmp   <= n_jmp;
            r_sel   <= n_sel;
            r_clr   <= n_clr;
            r_ovld  <= n_ovld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;

endmodule

`default_nettype wire

>>> rtl/core/geometric_median_pen_filter.sv
// ----------------------------------------------------------------------------
// geometric_median_pen_filter: pen-position median filter
// Weiszfeld geometric median over a ring of recent samples with a jump test.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tuser
//  s_axis    in   [31:0] sample_x [63:32] y      [0] op
//  m_axis    out  [31:0] out_x    [63:32] out_y  [0] window_cleared
//  cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (no read-back)
//
//  one transaction at a time; a clear op is taken in idle, a lone point goes straight to output
//  a window of n points computes the mean and then each refinement step
//  on the iterative root and divider, which serve every distance, weight
//  and mean; the jump test adds one more distance through the root
//  synchronous reset, no clearing pass
//  a result waiting on m_axis does not hold off the next input transaction
// ----------------------------------------------------------------------------
`default_nettype none

module geometric_median_pen_filter
    import gmp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [63:0]           s_axis_tdata,  // sample_x, sample_y
    input  wire logic [0:0]            s_axis_tuser,  // op
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic      [63:0]           m_axis_tdata,  // out_x, out_y
    output logic      [0:0]            m_axis_tuser,  // window_cleared
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ITER_W-1:0] r_iter;
    logic [THR_W-1:0]  r_thr;
    logic [WLEN_W-1:0] r_wlen;
    t_cmd              w_cmd;
    t_sts              w_sts;
    logic              w_in_ready;
    logic signed [COORD_W-1:0] w_ox, w_oy;
    logic              w_oclr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= ITER_RESET;
            r_thr  <= THR_RESET;
            r_wlen <= WLEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ITER: r_iter <= i_cfg_data[ITER_W-1:0];
                CFG_THR:  r_thr  <= i_cfg_data[THR_W-1:0];
                CFG_WLEN: r_wlen <= i_cfg_data[WLEN_W-1:0];
                default:  ;
            endcase
        end
    end

    gmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_op     (s_axis_tuser[0]),
        .o_in_ready  (w_in_ready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    gmp_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_sample_x        (s_axis_tdata[31:0]),
        .i_sample_y        (s_axis_tdata[63:32]),
        .i_iteration_count (r_iter),
        .i_jump_threshold  (r_thr),
        .i_window_length   (r_wlen),
        .o_out_x           (w_ox),
        .o_out_y           (w_oy),
        .o_window_cleared  (w_oclr)
    );

    assign s_axis_tready = w_in_ready;
    assign m_axis_tdata  = {w_oy, w_ox};
    assign m_axis_tuser  = w_oclr;

endmodule

`default_nettype wire
